// File: sv/cfpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_pkg
// Types, register indexes and the CRC-16/CCITT byte update shared by the
// command frame parser modules.
// ----------------------------------------------------------------------------
package cfpc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_INIT     = 2'd2;

    localparam logic [1:0] HDR_OPCODE = 2'd0;
    localparam logic [1:0] HDR_JOINT  = 2'd1;
    localparam logic [1:0] HDR_LENGTH = 2'd2;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        FR_HUNT,
        FR_SYNC,
        FR_HEADER,
        FR_PAYLOAD,
        FR_CRC_LO,
        FR_CRC_HI
    } front_state_t;

    typedef struct packed {
        logic [7:0]  start_first;
        logic [7:0]  start_second;
        logic [15:0] crc_init;
    } cfg_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] joint_id;
        logic [7:0] length;
        logic       slot;
    } desc_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] joint_id;
        logic [5:0] payload_length;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } res_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/command_frame_parser_crc16.sv
`default_nettype none
// Input: one byte per cycle; full rises only while two good frames wait in
// the descriptor queue, and falls when the older one has issued its last result.
// Result path: the first result of a good frame goes through the descriptor
// queue, the s1 register and the output queue to reach the result ports.
// Output: one result per cycle (single payload read port) if the queue has room.
// Reset: parser hunts for the first start byte, all queues empty; no clearing pass.
// ----------------------------------------------------------------------------
// command_frame_parser_crc16
// Scans a command byte stream for start-pair framed commands, checks the
// CRC-16/CCITT; a good frame gives one result per payload byte, or one if empty.
// ----------------------------------------------------------------------------
module command_frame_parser_crc16 import cfpc_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [7:0]             rx_byte,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [7:0]                  opcode,
    output logic [7:0]                  joint_id,
    output logic [5:0]                  payload_length,
    output logic [4:0]                  byte_index,
    output logic [7:0]                  payload_byte,
    output logic                        byte_valid,
    output logic                        last,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int KW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 << KW;

    cfg_t        cfg_reg, cfg_next;
    logic        mem_we;
    logic [KW:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [KW:0] mem_raddr;
    logic [7:0]  mem_rdata;
    logic        desc_push;
    desc_t       desc_in;
    logic        desc_pop;
    logic        desc_full;
    logic        desc_valid;
    desc_t       desc_head;
    res_t        result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_START_FIRST:  cfg_next.start_first  = cfg_data[7:0];
                REG_START_SECOND: cfg_next.start_second = cfg_data[7:0];
                REG_CRC_INIT:     cfg_next.crc_init     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first  <= 8'hAA;
            cfg_reg.start_second <= 8'h55;
            cfg_reg.crc_init     <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = desc_full;

    cfpc_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .KW         (KW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (desc_full),
        .rx_byte  (rx_byte),
        .mem_we   (mem_we),
        .mem_addr (mem_waddr),
        .mem_wdata(mem_wdata),
        .desc_push(desc_push),
        .desc     (desc_in)
    );

    cfpc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_payload_ram (
        .clk    (clk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    cfpc_desc_fifo u_desc_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (desc_push),
        .push_data(desc_in),
        .pop      (desc_pop),
        .full     (desc_full),
        .valid    (desc_valid),
        .head     (desc_head)
    );

    cfpc_back #(
        .KW(KW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc_valid(desc_valid),
        .desc      (desc_head),
        .desc_pop  (desc_pop),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign opcode         = result.opcode;
    assign joint_id       = result.joint_id;
    assign payload_length = result.payload_length;
    assign byte_index     = result.byte_index;
    assign payload_byte   = result.payload_byte;
    assign byte_valid     = result.byte_valid;
    assign last           = result.last;

    a_desc_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !desc_full)
        else $error("descriptor pushed into a full queue");

    a_empty_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (last && payload_byte == 8'h00 && byte_index == 5'd0))
        else $error("empty-payload result is malformed");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |-> desc_valid)
        else $error("descriptor released while queue is empty");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_valid && payload_length <= 6'd32)
            |-> ({1'b0, byte_index} < payload_length))
        else $error("byte index beyond payload length");

endmodule
`default_nettype wire

// File: sv/cfpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cfpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/cfpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_front
// Frame parser: hunts for the start pair, captures the header, writes the
// payload into one of two buffer slots and checks the CRC. A good frame is
// handed to the back end as a descriptor.
// ----------------------------------------------------------------------------
module cfpc_front import cfpc_pkg::*; #(
    parameter int MAX_PAYLOAD = 32,
    parameter int KW          = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          push,
    input  wire logic          full,
    input  wire logic [7:0]    rx_byte,
    output logic               mem_we,
    output logic [KW:0]        mem_addr,
    output logic [7:0]         mem_wdata,
    output logic               desc_push,
    output desc_t              desc
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    front_state_t  state_reg, state_next;
    logic [15:0]   crc_reg, crc_next;
    logic [1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]    opcode_reg, opcode_next;
    logic [7:0]    joint_reg, joint_next;
    logic [7:0]    len_reg, len_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [7:0]    crc_lo_reg, crc_lo_next;
    logic          slot_reg, slot_next;

    logic          take;
    logic [15:0]   crc_upd;
    logic [15:0]   crc_restart;
    logic          pay_last;

    assign take        = push && !full;
    assign crc_upd     = crc16_byte(crc_reg, rx_byte);
    assign crc_restart = crc16_byte(cfg.crc_init, rx_byte);
    assign pay_last    = (8'(cnt_reg) + 8'd1) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        if (take)
        begin
            case (state_reg)
                FR_HUNT:
                begin
                    if (rx_byte == cfg.start_first)
                    begin
                        state_next = FR_SYNC;
                    end
                end
                FR_SYNC:
                begin
                    if (rx_byte == cfg.start_second)
                    begin
                        state_next = FR_HEADER;
                    end
                    else if (rx_byte == cfg.start_first)
                    begin
                        state_next = FR_SYNC;
                    end
                    else
                    begin
                        state_next = FR_HUNT;
                    end
                end
                FR_HEADER:
                begin
                    if (hdr_cnt_reg == HDR_LENGTH)
                    begin
                        if (rx_byte > MAX_LEN)
                        begin
                            state_next = FR_HUNT;
                        end
                        else if (rx_byte == 8'd0)
                        begin
                            state_next = FR_CRC_LO;
                        end
                        else
                        begin
                            state_next = FR_PAYLOAD;
                        end
                    end
                end
                FR_PAYLOAD:
                begin
                    if (pay_last)
                    begin
                        state_next = FR_CRC_LO;
                    end
                end
                FR_CRC_LO:
                begin
                    state_next = FR_CRC_HI;
                end
                FR_CRC_HI:
                begin
                    state_next = FR_HUNT;
                end
                default:
                begin
                    state_next = FR_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        crc_next     = crc_reg;
        hdr_cnt_next = hdr_cnt_reg;
        opcode_next  = opcode_reg;
        joint_next   = joint_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        crc_lo_next  = crc_lo_reg;
        slot_next    = slot_reg;
        mem_we       = 1'b0;
        desc_push    = 1'b0;
        if (take)
        begin
            case (state_reg)
                FR_HUNT:
                begin
                    if (rx_byte == cfg.start_first)
                    begin
                        crc_next = crc_restart;
                    end
                end
                FR_SYNC:
                begin
                    if (rx_byte == cfg.start_second)
                    begin
                        crc_next     = crc_upd;
                        hdr_cnt_next = HDR_OPCODE;
                    end
                    else if (rx_byte == cfg.start_first)
                    begin
                        crc_next = crc_restart;
                    end
                end
                FR_HEADER:
                begin
                    crc_next     = crc_upd;
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    cnt_next     = '0;
                    case (hdr_cnt_reg)
                        HDR_OPCODE: opcode_next = rx_byte;
                        HDR_JOINT:  joint_next  = rx_byte;
                        default:    len_next    = rx_byte;
                    endcase
                end
                FR_PAYLOAD:
                begin
                    mem_we   = 1'b1;
                    crc_next = crc_upd;
                    cnt_next = cnt_reg + 1'b1;
                end
                FR_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                end
                FR_CRC_HI:
                begin
                    if ({rx_byte, crc_lo_reg} == crc_reg)
                    begin
                        desc_push = 1'b1;
                        slot_next = ~slot_reg;
                    end
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    assign mem_addr      = {slot_reg, cnt_reg};
    assign mem_wdata     = rx_byte;
    assign desc.opcode   = opcode_reg;
    assign desc.joint_id = joint_reg;
    assign desc.length   = len_reg;
    assign desc.slot     = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_HUNT;
            slot_reg  <= 1'b0;
            crc_reg   <= 16'hFFFF;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_cnt_reg <= hdr_cnt_next;
        opcode_reg  <= opcode_next;
        joint_reg   <= joint_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        crc_lo_reg  <= crc_lo_next;
    end

endmodule
`default_nettype wire

// File: sv/cfpc_desc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_desc_fifo
// Two-entry queue of accepted frame descriptors between the parser and the
// result generator. An entry leaves when its last result has been issued.
// ----------------------------------------------------------------------------
module cfpc_desc_fifo import cfpc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_data,
    input  wire logic  pop,
    output logic       full,
    output logic       valid,
    output desc_t      head
);

    desc_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = count_reg == 2'd2;
    assign valid   = count_reg != 2'd0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/cfpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_back
// Result generator: walks the payload of the frame at the head of the
// descriptor queue, one buffer read a cycle while the output queue has
// room, and collects the results in a four-entry output queue.
// ----------------------------------------------------------------------------
module cfpc_back import cfpc_pkg::*; #(
    parameter int KW = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          desc_valid,
    input  wire desc_t         desc,
    output logic               desc_pop,
    output logic [KW:0]        mem_raddr,
    input  wire logic [7:0]    mem_rdata,
    input  wire logic          pop,
    output logic               empty,
    output res_t               result
);

    localparam int         QDEPTH = 4;
    localparam int         QPW    = $clog2(QDEPTH);
    localparam logic [QPW:0] QFULL = (QPW+1)'(QDEPTH);

    logic [KW-1:0]  idx_reg, idx_next;
    logic           s1_valid_reg;
    res_t           s1_reg;
    res_t           q_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW:0]   count_reg, count_next;

    logic           issue;
    logic           zero_len;
    logic           issue_last;
    logic           q_pop;
    res_t           entry;

    assign zero_len   = desc.length == 8'd0;
    assign issue      = desc_valid && ((count_reg + (QPW+1)'(s1_valid_reg)) < QFULL);
    assign issue_last = zero_len || ((8'(idx_reg) + 8'd1) == desc.length);
    assign desc_pop   = issue && issue_last;
    assign mem_raddr  = {desc.slot, idx_reg};

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = issue_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        entry              = s1_reg;
        entry.payload_byte = s1_reg.byte_valid ? mem_rdata : 8'h00;
    end

    assign q_pop      = pop && !empty;
    assign count_next = count_reg + (QPW+1)'(s1_valid_reg) - (QPW+1)'(q_pop);
    assign empty      = count_reg == '0;
    assign result     = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s1_valid_reg <= issue;
            count_reg    <= count_next;
            if (s1_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg.opcode         <= desc.opcode;
            s1_reg.joint_id       <= desc.joint_id;
            s1_reg.payload_length <= desc.length[5:0];
            s1_reg.byte_index     <= 5'(idx_reg);
            s1_reg.payload_byte   <= 8'h00;
            s1_reg.byte_valid     <= !zero_len;
            s1_reg.last           <= issue_last;
        end
        if (s1_valid_reg)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for command_frame_parser_crc16. Byte streams of well-formed,
// corrupted, over-long, truncated and noisy command frames are pushed under
// several start-byte and CRC-seed settings. Every popped beat is compared
// field by field with a behavioral frame parser kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfpc_pkg::*;

    localparam int MAX_PAY       = 32;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        ROW_FRAME,
        ROW_RESTART,
        ROW_HUNT,
        ROW_NOISE,
        ROW_PARTIAL
    } row_kind_t;

    typedef enum logic [1:0] {
        FILL_CONST,
        FILL_RAMP,
        FILL_RANDOM
    } fill_mode_t;

    typedef enum logic [1:0] {
        DRAIN_FULL,
        DRAIN_COIN,
        DRAIN_SLOW,
        DRAIN_TRICKLE
    } drain_mode_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] op;
        logic [7:0] joint;
        logic [7:0] len;
        fill_mode_t fill_mode;
        logic [7:0] fill;
        logic       corrupt;
        int         beats;
    } frame_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             rx_byte;
    logic                   empty;
    logic                   pop;
    logic [7:0]             opcode;
    logic [7:0]             joint_id;
    logic [5:0]             payload_length;
    logic [4:0]             byte_index;
    logic [7:0]             payload_byte;
    logic                   byte_valid;
    logic                   last;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    command_frame_parser_crc16 DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .opcode         (opcode),
        .joint_id       (joint_id),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    logic [7:0]  cfg_first;
    logic [7:0]  cfg_second;
    logic [15:0] cfg_crc_init;

    int          frame_pos;
    logic [7:0]  hdr_op;
    logic [7:0]  hdr_joint;
    logic [7:0]  hdr_len;
    logic [7:0]  payload_buf [MAX_PAY];
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo_seen;

    res_t        payload_beats_due [$];
    logic [7:0]  frame_bytes [$];
    int          beats_predicted;
    int          bytes_sent;
    int          mismatch_count;
    int          burst_left;

    drain_mode_t drain_mode;
    int          drain_left;
    int          drain_tick;

    frame_row_t directed_rows [16] = '{
        '{ROW_FRAME,   8'h00, 8'h00, 8'd0,   FILL_CONST,  8'h00, 1'b0,  1},
        '{ROW_FRAME,   8'hFF, 8'hFF, 8'd1,   FILL_CONST,  8'hFF, 1'b0,  1},
        '{ROW_FRAME,   8'h01, 8'h02, 8'd3,   FILL_RAMP,   8'h10, 1'b0, -1},
        '{ROW_FRAME,   8'h3C, 8'hC3, 8'd32,  FILL_RAMP,   8'hE0, 1'b0, 32},
        '{ROW_FRAME,   8'h11, 8'h22, 8'd5,   FILL_RANDOM, 8'h00, 1'b1,  0},
        '{ROW_FRAME,   8'h12, 8'h34, 8'd33,  FILL_CONST,  8'h00, 1'b0,  0},
        '{ROW_FRAME,   8'h7E, 8'h81, 8'd0,   FILL_CONST,  8'h00, 1'b0,  1},
        '{ROW_FRAME,   8'h56, 8'h78, 8'd255, FILL_CONST,  8'h00, 1'b0,  0},
        '{ROW_RESTART, 8'h20, 8'h01, 8'd2,   FILL_RANDOM, 8'h00, 1'b0,  2},
        '{ROW_HUNT,    8'h00, 8'h00, 8'd0,   FILL_CONST,  8'h00, 1'b0,  0},
        '{ROW_NOISE,   8'h00, 8'h00, 8'd3,   FILL_CONST,  8'h55, 1'b0,  0},
        '{ROW_FRAME,   8'hA5, 8'h5A, 8'd4,   FILL_CONST,  8'hAA, 1'b0,  4},
        '{ROW_FRAME,   8'h42, 8'h07, 8'd31,  FILL_RANDOM, 8'h00, 1'b0, -1},
        '{ROW_FRAME,   8'h00, 8'hFF, 8'd1,   FILL_CONST,  8'h00, 1'b1,  0},
        '{ROW_FRAME,   8'h99, 8'h66, 8'd6,   FILL_RANDOM, 8'h00, 1'b0, -1},
        '{ROW_PARTIAL, 8'h00, 8'h00, 8'd0,   FILL_CONST,  8'h00, 1'b0,  0}
    };

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [15:0] ccitt_next(input logic [15:0] crc,
                                               input logic [7:0]  d);
        logic        fb;
        logic [15:0] c;
        int          k;
        c = crc;
        for (k = 7; k >= 0; k--) begin
            fb = c[15] ^ d[k];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ 16'h1021;
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic track_frame_byte(input logic [7:0] b);
        res_t        beat;
        logic [15:0] rx_crc;
        int          len;
        int          i;
        len = hdr_len;
        if (frame_pos == 0)
        begin
            if (b == cfg_first)
            begin
                crc_acc   = ccitt_next(cfg_crc_init, b);
                frame_pos = 1;
            end
        end
        else if (frame_pos == 1)
        begin
            if (b == cfg_second)
            begin
                crc_acc   = ccitt_next(crc_acc, b);
                frame_pos = 2;
            end
            else if (b == cfg_first)
            begin
                crc_acc = ccitt_next(cfg_crc_init, b);
            end
            else
            begin
                frame_pos = 0;
            end
        end
        else if (frame_pos < 5)
        begin
            case (frame_pos)
                2:       hdr_op    = b;
                3:       hdr_joint = b;
                default: hdr_len   = b;
            endcase
            crc_acc = ccitt_next(crc_acc, b);
            frame_pos++;
            if (frame_pos == 5 && b > MAX_PAY)
            begin
                frame_pos = 0;
            end
        end
        else if (frame_pos < 5 + len)
        begin
            payload_buf[frame_pos - 5] = b;
            crc_acc = ccitt_next(crc_acc, b);
            frame_pos++;
        end
        else if (frame_pos == 5 + len)
        begin
            crc_lo_seen = b;
            frame_pos++;
        end
        else
        begin
            rx_crc    = {b, crc_lo_seen};
            frame_pos = 0;
            if (rx_crc == crc_acc)
            begin
                if (len == 0)
                begin
                    beat = '{opcode: hdr_op, joint_id: hdr_joint, payload_length: 6'd0,
                             byte_index: 5'd0, payload_byte: 8'h00, byte_valid: 1'b0,
                             last: 1'b1};
                    payload_beats_due.push_back(beat);
                    beats_predicted++;
                end
                for (i = 0; i < len; i++) begin
                    beat = '{opcode: hdr_op, joint_id: hdr_joint, payload_length: 6'(len),
                             byte_index: 5'(i), payload_byte: payload_buf[i],
                             byte_valid: 1'b1, last: (i == len - 1)};
                    payload_beats_due.push_back(beat);
                    beats_predicted++;
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        track_frame_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_bytes.size(); k++) begin
            send_byte(frame_bytes[k]);
        end
    endtask

    task automatic build_frame(input logic [7:0] op, input logic [7:0] joint,
                               input logic [7:0] len, input fill_mode_t fm,
                               input logic [7:0] fill, input logic corrupt);
        logic [15:0] crc;
        logic [7:0]  d;
        int          k;
        frame_bytes.delete();
        frame_bytes.push_back(cfg_first);
        frame_bytes.push_back(cfg_second);
        frame_bytes.push_back(op);
        frame_bytes.push_back(joint);
        frame_bytes.push_back(len);
        crc = cfg_crc_init;
        for (k = 0; k < 5; k++) begin
            crc = ccitt_next(crc, frame_bytes[k]);
        end
        if (len > MAX_PAY)
        begin
            return;
        end
        for (k = 0; k < len; k++) begin
            case (fm)
                FILL_CONST: d = fill;
                FILL_RAMP:  d = fill + 8'(k);
                default:    d = 8'($urandom_range(0, 255));
            endcase
            frame_bytes.push_back(d);
            crc = ccitt_next(crc, d);
        end
        if (corrupt)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic run_row(input frame_row_t row);
        int beats_at_start;
        int k;
        beats_at_start = beats_predicted;
        frame_bytes.delete();
        case (row.kind)
            ROW_FRAME:
            begin
                build_frame(row.op, row.joint, row.len, row.fill_mode, row.fill, row.corrupt);
            end
            ROW_RESTART:
            begin
                build_frame(row.op, row.joint, row.len, row.fill_mode, row.fill, row.corrupt);
                frame_bytes.push_front(cfg_first);
            end
            ROW_HUNT:
            begin
                frame_bytes.push_back(cfg_first);
                frame_bytes.push_back(row.op);
            end
            ROW_NOISE:
            begin
                for (k = 0; k < row.len; k++) begin
                    frame_bytes.push_back(row.fill_mode == FILL_RANDOM ?
                                          8'($urandom_range(0, 255)) : row.fill + 8'(k));
                end
            end
            default:
            begin
                frame_bytes.push_back(cfg_first);
            end
        endcase
        send_frame();
        if (row.beats >= 0 && beats_predicted - beats_at_start != row.beats)
        begin
            report_mismatch($sformatf("row op=%02h len=%0d: %0d beats predicted, %0d listed",
                                      row.op, row.len, beats_predicted - beats_at_start,
                                      row.beats));
        end
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        while (payload_beats_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] first, input logic [7:0] second,
                                input logic [15:0] init);
        cfg_write <= 1'b1;
        cfg_index <= REG_START_FIRST;
        cfg_data  <= CFG_DATA_W'(first);
        @(posedge clk);
        cfg_index <= REG_START_SECOND;
        cfg_data  <= CFG_DATA_W'(second);
        @(posedge clk);
        cfg_index <= REG_CRC_INIT;
        cfg_data  <= init;
        @(posedge clk);
        cfg_write    <= 1'b0;
        cfg_first    = first;
        cfg_second   = second;
        cfg_crc_init = init;
    endtask

    task automatic run_random(input int byte_goal, input int beat_goal);
        int         start_bytes;
        int         start_beats;
        int         pick;
        int         r;
        int         k;
        logic [7:0] len;
        start_bytes = bytes_sent;
        start_beats = beats_predicted;
        while (bytes_sent - start_bytes < byte_goal ||
               beats_predicted - start_beats < beat_goal) begin
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            len  = (r < 70) ? 8'($urandom_range(0, 6)) :
                   (r < 96) ? 8'($urandom_range(7, 31)) : 8'(MAX_PAY);
            frame_bytes.delete();
            if (pick < 65)
            begin
                build_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM, 8'h00, 1'b0);
            end
            else if (pick < 73)
            begin
                build_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM, 8'h00, 1'b1);
            end
            else if (pick < 78)
            begin
                build_frame(8'($urandom), 8'($urandom), 8'($urandom_range(MAX_PAY + 1, 255)),
                            FILL_RANDOM, 8'h00, 1'b0);
            end
            else if (pick < 83)
            begin
                build_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM, 8'h00, 1'b0);
                frame_bytes.push_front(cfg_first);
            end
            else if (pick < 87)
            begin
                build_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM, 8'h00, 1'b0);
                repeat ($urandom_range(1, 3)) void'(frame_bytes.pop_back());
            end
            else if (pick < 91)
            begin
                frame_bytes.push_back(cfg_first);
                frame_bytes.push_back(8'($urandom));
            end
            else
            begin
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    frame_bytes.push_back(8'($urandom));
                end
            end
            send_frame();
            if ($urandom_range(0, 49) == 0)
            begin
                drain_and_settle();
            end
        end
    endtask

    always @(posedge clk) begin
        if (drain_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 3));
            drain_left = $urandom_range(20, 200);
        end
        drain_left--;
        drain_tick = (drain_tick + 1) % 8;
        case (drain_mode)
            DRAIN_FULL: pop <= 1'b1;
            DRAIN_COIN: pop <= 1'($urandom_range(0, 1));
            DRAIN_SLOW: pop <= (drain_tick == 0);
            default:    pop <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk) begin : result_check
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (payload_beats_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat op=%02h joint=%02h index=%0d",
                                          opcode, joint_id, byte_index));
            end
            else
            begin
                want = payload_beats_due.pop_front();
                if (opcode !== want.opcode)
                    report_mismatch($sformatf("opcode %02h, want %02h", opcode, want.opcode));
                if (joint_id !== want.joint_id)
                    report_mismatch($sformatf("joint_id %02h, want %02h",
                                              joint_id, want.joint_id));
                if (payload_length !== want.payload_length)
                    report_mismatch($sformatf("payload_length %0d, want %0d",
                                              payload_length, want.payload_length));
                if (byte_index !== want.byte_index)
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              byte_index, want.byte_index));
                if (payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %02h, want %02h at index %0d",
                                              payload_byte, want.payload_byte,
                                              want.byte_index));
                if (byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, want %b",
                                              byte_valid, want.byte_valid));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, want %b at index %0d",
                                              last, want.last, want.byte_index));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int r;
        rst_n           = 1'b0;
        push            = 1'b0;
        rx_byte         = 8'h00;
        pop             = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_START_FIRST;
        cfg_data        = '0;
        cfg_first       = 8'hAA;
        cfg_second      = 8'h55;
        cfg_crc_init    = 16'hFFFF;
        frame_pos       = 0;
        hdr_op          = 8'h00;
        hdr_joint       = 8'h00;
        hdr_len         = 8'h00;
        crc_acc         = 16'hFFFF;
        crc_lo_seen     = 8'h00;
        beats_predicted = 0;
        bytes_sent      = 0;
        mismatch_count  = 0;
        burst_left      = 0;
        drain_mode      = DRAIN_FULL;
        drain_left      = 0;
        drain_tick      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(directed_rows); r++) begin
            run_row(directed_rows[r]);
        end

        // A start byte is still pending here, so the new start bytes apply mid-frame.
        drain_and_settle();
        write_config(8'hFF, 8'h00, 16'h0000);
        run_random(25, 0);

        drain_and_settle();
        write_config(8'h5A, 8'h5A, 16'h1D0F);
        run_row('{ROW_FRAME, 8'h5A, 8'h5A, 8'd2, FILL_CONST, 8'h5A, 1'b0, -1});
        run_random(25, 0);

        drain_and_settle();
        write_config(8'h00, 8'hFF, 16'hFFFF);
        run_random(25, 0);

        drain_and_settle();
        write_config(8'hAA, 8'h55, 16'hFFFF);
        run_random(25, 8);

        drain_and_settle();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
